### rtl/hst_pkg.sv
// Shared types, codes and defaults for the hash set table.
`default_nettype none

package hst_pkg;

  localparam int KEY_W              = 32;
  localparam int NUM_BUCKETS_DEF    = 31;
  localparam int SLOTS_PER_BUCKET_DEF = 4;

  typedef logic [1:0]              op_t;
  typedef logic signed [KEY_W-1:0] key_t;

  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_TEST   = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

`default_nettype wire

### rtl/hst_in_if.sv
// Request channel: operation and key, valid/ready handshake.
`default_nettype none

interface hst_in_if;
  import hst_pkg::*;

  logic valid;
  logic ready;
  op_t  op;
  key_t key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

`default_nettype wire

### rtl/hst_out_if.sv
// Result channel: presence flag and status, valid/ready handshake.
`default_nettype none

interface hst_out_if;
  logic valid;
  logic ready;
  logic was_present;
  logic status;

  modport source (output valid, output was_present, output status, input ready);
  modport sink   (input valid, input was_present, input status, output ready);
endinterface

`default_nettype wire

### rtl/hst_mod_unit.sv
// Multiplier-based unit giving the non-negative remainder of a signed key modulo the bucket count.
`default_nettype none

module hst_mod_unit #(
  parameter int NUM_BUCKETS = hst_pkg::NUM_BUCKETS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire hst_pkg::key_t                  key,
  output logic                                done,
  output logic [$clog2(NUM_BUCKETS)-1:0]      rem
);
  import hst_pkg::*;

  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int HALF  = KEY_W / 2;
  // hi * (2^16 mod N) + lo stays below 2^(HALF+BW)
  localparam int T_W   = HALF + BW;
  localparam int M_W   = T_W + 1;
  localparam int Q_W   = HALF + 1;
  localparam int SHIFT = T_W + BW;
  localparam int P_W   = T_W + M_W;

  localparam logic [63:0]    N64    = 64'(NUM_BUCKETS);
  localparam logic [M_W-1:0] HI_WT  = M_W'((64'd1 << HALF) % N64);
  localparam logic [M_W-1:0] RECIP  = M_W'((64'd1 << SHIFT) / N64);
  localparam logic [M_W-1:0] N_OP   = M_W'(NUM_BUCKETS);
  // 2^32 mod N: offset between the unsigned and signed reading of a negative key
  localparam logic [BW-1:0]  WRAP   = BW'((64'd1 << KEY_W) % N64);
  localparam logic [BW-1:0]  ADD_BK = BW'(N64 - ((64'd1 << KEY_W) % N64));
  localparam logic [BW:0]    DIVSOR = (BW+1)'(NUM_BUCKETS);

  localparam logic [2:0] MS_IDLE  = 3'd0;
  localparam logic [2:0] MS_SPLIT = 3'd1;
  localparam logic [2:0] MS_RECIP = 3'd2;
  localparam logic [2:0] MS_BACK  = 3'd3;
  localparam logic [2:0] MS_TRIM  = 3'd4;
  localparam logic [2:0] MS_FOLD  = 3'd5;

  logic [2:0]       step_r, step_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [KEY_W-1:0] src_r, src_nxt;
  logic [T_W-1:0]   t_r, t_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [BW:0]      rest_r, rest_nxt;
  logic [BW-1:0]    rem_r, rem_nxt;
  logic [T_W-1:0]   mul_a;
  logic [M_W-1:0]   mul_b;
  logic [P_W-1:0]   prod;

  // one multiplier, operands chosen by the step
  always_comb begin
    unique case (step_r)
      MS_SPLIT: begin
        mul_a = T_W'(src_r[KEY_W-1:HALF]);
        mul_b = HI_WT;
      end
      MS_RECIP: begin
        mul_a = t_r;
        mul_b = RECIP;
      end
      MS_BACK: begin
        mul_a = T_W'(q_r);
        mul_b = N_OP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = P_W'(mul_a) * P_W'(mul_b);

  always_comb begin
    step_nxt = step_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    src_nxt  = src_r;
    t_nxt    = t_r;
    q_nxt    = q_r;
    rest_nxt = rest_r;
    rem_nxt  = rem_r;
    if (start) begin
      step_nxt = MS_SPLIT;
      neg_nxt  = key[KEY_W-1];
      src_nxt  = key;
    end else begin
      unique case (step_r)
        MS_SPLIT: begin
          // fold the upper half in; the remainder is unchanged
          t_nxt    = prod[T_W-1:0] + T_W'(src_r[HALF-1:0]);
          step_nxt = MS_RECIP;
        end
        MS_RECIP: begin
          // quotient estimate, low by at most one
          q_nxt    = prod[SHIFT +: Q_W];
          step_nxt = MS_BACK;
        end
        MS_BACK: begin
          rest_nxt = (BW+1)'(t_r - prod[T_W-1:0]);
          step_nxt = MS_TRIM;
        end
        MS_TRIM: begin
          rem_nxt  = (rest_r >= DIVSOR) ? BW'(rest_r - DIVSOR) : rest_r[BW-1:0];
          step_nxt = MS_FOLD;
        end
        MS_FOLD: begin
          // fold the unsigned remainder back to the signed one
          if (neg_r) begin
            rem_nxt = (rem_r >= WRAP) ? rem_r - WRAP : rem_r + ADD_BK;
          end
          done_nxt = 1'b1;
          step_nxt = MS_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= MS_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    src_r  <= src_nxt;
    t_r    <= t_nxt;
    q_r    <= q_nxt;
    rest_r <= rest_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

### rtl/hash_set_table_core.sv
// Hash set of signed keys: bucket rows in memory, multiplier-based modulo hash, row compare and write-back.
//
//   channel | dir | payload                 | handshake
//   in_chan | in  | op[1:0], key[31:0] s    | valid/ready, taken when both high
//   out_chan| out | was_present, status     | valid/ready, taken when both high
//
// An item passes from acceptance to its result being offered through the
// hst_mod_unit steps (fold the key halves, reciprocal multiply, multiply back,
// trim, sign fold), the bucket latch, the row read and the compare/write-back.
// in_chan.ready returns the cycle after write-back, so no new item is taken
// before the last one is written back. After reset a clearing pass empties
// every row; no item is taken meanwhile. A result waiting on out_chan does not
// block the next item; a finished item holds in write-back until the result register frees.
`default_nettype none

module hash_set_table_core #(
  parameter int NUM_BUCKETS      = hst_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = hst_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hst_in_if.sink      in_chan,
  hst_out_if.source   out_chan
);
  import hst_pkg::*;

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int S  = SLOTS_PER_BUCKET;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_HASH   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [BW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [BW-1:0] bucket_r, bucket_nxt;
  op_t           op_r, op_nxt;
  key_t          key_r, key_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          present_r, present_nxt;
  logic          status_r, status_nxt;

  logic [S-1:0]            valid_mem [NUM_BUCKETS];
  logic [S-1:0][KEY_W-1:0] key_mem   [NUM_BUCKETS];
  logic [S-1:0]            row_valid_r;
  logic [S-1:0][KEY_W-1:0] row_key_r;

  logic                    wr_en;
  logic                    key_wr_en;
  logic [BW-1:0]           wr_addr;
  logic [S-1:0]            wr_valid;
  logic [S-1:0][KEY_W-1:0] wr_key;

  logic          accept;
  logic          mod_done;
  logic [BW-1:0] mod_rem;

  logic [S-1:0]  hit_vec, hit_oh, free_vec, free_oh;
  logic          hit_any, free_any;
  logic          out_free;

  hst_mod_unit #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_chan.key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // compare every slot of the row at once, pick the lowest match and free slot
  always_comb begin
    for (int s = 0; s < S; s++) begin
      hit_vec[s] = row_valid_r[s] && (row_key_r[s] == key_r);
    end
    free_vec = ~row_valid_r;
    hit_oh   = hit_vec & (~hit_vec + S'(1));
    free_oh  = free_vec & (~free_vec + S'(1));
    hit_any  = |hit_vec;
    free_any = |free_vec;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    bucket_nxt    = bucket_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    present_nxt   = present_r;
    status_nxt    = status_r;
    wr_en         = 1'b0;
    key_wr_en     = 1'b0;
    wr_addr       = bucket_r;
    wr_valid      = row_valid_r;
    wr_key        = row_key_r;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr_cnt_r;
        wr_valid = '0;
        clr_cnt_nxt = clr_cnt_r + BW'(1);
        if (clr_cnt_r == BW'(NUM_BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_chan.op;
          key_nxt   = in_chan.key;
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          bucket_nxt = mod_rem;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold until the result register can take this item
        if (out_free) begin
          out_valid_nxt = 1'b1;
          present_nxt   = hit_any;
          status_nxt    = STATUS_DONE;
          unique case (op_r)
            OP_ADD: begin
              if (!hit_any) begin
                if (free_any) begin
                  wr_en     = 1'b1;
                  key_wr_en = 1'b1;
                  wr_valid  = row_valid_r | free_oh;
                  for (int s = 0; s < S; s++) begin
                    if (free_oh[s]) begin
                      wr_key[s] = key_r;
                    end
                  end
                end else begin
                  status_nxt = STATUS_FULL;
                end
              end
            end
            OP_REMOVE: begin
              if (hit_any) begin
                wr_en    = 1'b1;
                wr_valid = row_valid_r & ~hit_oh;
              end
            end
            OP_TEST: begin
            end
            default: begin
              // undefined code: behave as a test
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bucket_r  <= bucket_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    present_r <= present_nxt;
    status_r  <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      valid_mem[wr_addr] <= wr_valid;
    end
    if (key_wr_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (state_r == ST_READ) begin
      row_valid_r <= valid_mem[bucket_r];
      row_key_r   <= key_mem[bucket_r];
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.was_present = present_r;
  assign out_chan.status      = status_r;

endmodule

`default_nettype wire
